@@ rtl/core/ir_curtain_fall_detector_assert.svh @@
// assertion macros for the ir curtain fall detector
`ifndef IR_CURTAIN_FALL_DETECTOR_ASSERT_SVH
`define IR_CURTAIN_FALL_DETECTOR_ASSERT_SVH
`ifndef SYNTH
`define IRCF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ircf assertion failed");
`define IRCF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ircf assertion failed");
`else
`define IRCF_ASSERT(lbl, clk, rstn, prop)
`define IRCF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/core/ircf_pkg.sv @@
// ----------------------------------------------------------------------------
// ircf_pkg
// types, codes and widths shared by the ir curtain fall detector
// ----------------------------------------------------------------------------
package ircf_pkg;

  localparam int FUNC_W   = 3;
  localparam int ADC_W    = 10;
  localparam int CNT_W    = 10;
  localparam int SUM_W    = 20;
  localparam int TOT_W    = 24;
  localparam int RND_W    = 14;
  localparam int WP_W     = 3;
  localparam int FLAG_W   = 16;
  localparam int STATUS_W = 3;
  localparam int LIT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int CHANNELS_DEF = 16;

  localparam logic [CNT_W-1:0] AVG_RST   = 10'd400;
  localparam logic [CNT_W-1:0] TH_RST    = 10'd100;
  localparam logic [CNT_W-1:0] TL_RST    = 10'd50;
  localparam logic [SUM_W-1:0] FLOOR_RST = 20'd300;
  localparam logic [SUM_W-1:0] CEIL_RST  = 20'd368280;
  localparam logic [WP_W-1:0]  WP_SAMPLE = 3'd3;
  localparam logic [WP_W-1:0]  WP_GROUP  = 3'd5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE  = 3'd0,
    FUNC_ADVANCE = 3'd1,
    FUNC_START   = 3'd2,
    FUNC_STOP    = 3'd3,
    FUNC_RESTART = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_NORMAL    = 3'd0,
    STAT_FALL      = 3'd1,
    STAT_RANGE     = 3'd2,
    STAT_NOT_READY = 3'd3,
    STAT_OFF       = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG   = 3'd0,
    CFG_TH    = 3'd1,
    CFG_TL    = 3'd2,
    CFG_CLEAR = 3'd3,
    CFG_FLOOR = 3'd4,
    CFG_CEIL  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIVB, S_DIVT, S_EVAL, S_LATCH, S_SCAN, S_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [TOT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/core/ircf_div.sv @@
// ----------------------------------------------------------------------------
// ircf_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ircf_div import ircf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [TOT_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(TOT_W);

  logic [CNT_W-1:0]  rem_q;
  logic [TOT_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[TOT_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(TOT_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(TOT_W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      // zero divisor acts as one
      dvs_q <= (req_i.divisor == '0) ? CNT_W'(1) : req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[TOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/core/ir_curtain_fall_detector.sv @@
// ----------------------------------------------------------------------------
// ir_curtain_fall_detector
// ir curtain scanner: per-channel baselines, fall flags and status
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tuser: func[2:0]; tdata: sample[9:0]
// m_axis    out        tdata: fall_flags, status, lit_channel, led_drive
// cfg       in         write enable, register index, write data
//
// one request at a time: most requests pass the exec, scan and output steps; a
// sample after the baselines are set also waits for two runs of the serial
// divider and an eval step, plus the latch step when baselines re-latch.
// every request ends with a scan of all baselines for range.
// reset is asynchronous, active low; a stalled result holds the following
// request in its output step, and no further request is taken in meanwhile.
module ir_curtain_fall_detector import ircf_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample[9:0], zero fill
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // flags[15:0] status[18:16]
                                                 // lit[22:19] led[23]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "ir_curtain_fall_detector_assert.svh"

  localparam int CW = $clog2(CHANNELS);
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  // configuration
  logic [CNT_W-1:0] avg_q, th_q, tl_q;
  logic             clr_en_q;
  logic [SUM_W-1:0] floor_q, ceil_q;

  // control state
  state_e            state_q, state_d;
  logic [CW-1:0]     ch_q, idx_q;
  logic              enabled_q, ready_q, restart_q, event_q, bad_q;
  logic [CNT_W-1:0]  rc_q;
  logic [WP_W-1:0]   wp_q;
  logic [FLAG_W-1:0] flags_q;
  logic [SUM_W-1:0]  pend_q [CHANNELS];
  logic [SUM_W-1:0]  bsum_q [CHANNELS];
  logic [TOT_W-1:0]  total_q, acc_q;
  logic [RND_W-1:0]  rsum_q;

  // request
  logic [FUNC_W-1:0] func_q;
  logic [ADC_W-1:0]  adc_q;
  logic [SUM_W-1:0]  bq_q;
  logic [TOT_W-1:0]  tq_q;

  // output register
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  div_req_t          div_req;
  logic              div_done;
  logic [TOT_W-1:0]  div_quot;

  ircf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // shared combinational terms
  logic              last_ch, accept, out_load;
  logic [CNT_W-1:0]  rc_new;
  logic              win_end;
  logic [SUM_W:0]    pend_add;
  logic [SUM_W-1:0]  pend_sat;
  logic [FLAG_W-1:0] ch_bit, all_mask, flags_new;
  logic [RND_W:0]    rs_add;
  logic [RND_W-1:0]  rs_new;
  logic [SUM_W:0]    hi_lim, lo_hi, adc_lo, base_w, adc_w;
  logic [TOT_W+1:0]  tot_lim;
  logic              hit, all_hit, clr_hit, ev_new;
  logic [WP_W-1:0]   wp_new;
  logic [TOT_W:0]    acc_add;
  logic [TOT_W-1:0]  acc_sat;
  logic              sample_div;

  assign last_ch = ch_q == LAST_CH;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    rc_new = rc_q;
    if (ch_q == '0 && rc_q != '1) rc_new = rc_q + 1'b1;
  end
  assign win_end = (rc_new >= avg_q) && last_ch;

  assign pend_add = {1'b0, pend_q[idx_q]} + (SUM_W + 1)'(adc_q);
  assign pend_sat = pend_add[SUM_W] ? '1 : pend_add[SUM_W-1:0];
  assign acc_add  = {1'b0, acc_q} + (TOT_W + 1)'(pend_q[idx_q]);
  assign acc_sat  = acc_add[TOT_W] ? '1 : acc_add[TOT_W-1:0];

  always_comb begin
    for (int i = 0; i < FLAG_W; i++) begin
      ch_bit[i]   = int'(ch_q) == i;
      all_mask[i] = i < CHANNELS;
    end
  end

  // sample evaluation once both quotients are in
  always_comb begin
    rs_add  = {1'b0, rsum_q} + (RND_W + 1)'(adc_q);
    rs_new  = rs_add[RND_W] ? '1 : rs_add[RND_W-1:0];
    base_w  = {1'b0, bq_q};
    adc_w   = (SUM_W + 1)'(adc_q);
    hi_lim  = base_w + (SUM_W + 1)'(th_q);
    lo_hi   = base_w + (SUM_W + 1)'(tl_q);
    adc_lo  = adc_w + (SUM_W + 1)'(tl_q);
    tot_lim = (TOT_W + 2)'(tq_q) + (TOT_W + 2)'(th_q) * (TOT_W + 2)'(3);
    hit     = adc_w > hi_lim;
    all_hit = last_ch && ((TOT_W + 2)'(rs_new) > tot_lim);
    clr_hit = clr_en_q && (adc_w < lo_hi) && (adc_lo > base_w);
    ev_new  = event_q || hit || all_hit;
    flags_new = flags_q;
    if (hit) flags_new = flags_new | ch_bit;
    if (all_hit) flags_new = all_mask;
    if (clr_hit) flags_new = flags_new & ~ch_bit;
    wp_new  = win_end ? wp_q + 1'b1 : wp_q;
  end

  assign sample_div = (func_q == FUNC_SAMPLE) && !restart_q && ready_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_SCAN;
        if (func_q == FUNC_SAMPLE && !restart_q) begin
          if (ready_q) state_d = S_DIVB;
          else if (win_end) state_d = S_LATCH;
        end
      end
      S_DIVB: if (div_done) state_d = S_DIVT;
      S_DIVT: if (div_done) state_d = S_EVAL;
      S_EVAL: begin
        state_d = S_SCAN;
        if (wp_new != WP_SAMPLE && wp_new >= WP_GROUP && !ev_new) state_d = S_LATCH;
      end
      S_LATCH: if (idx_q == LAST_CH) state_d = S_SCAN;
      S_SCAN:  if (idx_q == LAST_CH) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready    = state_q == S_IDLE;
    div_req.start    = 1'b0;
    div_req.dividend = TOT_W'(bsum_q[idx_q]);
    div_req.divisor  = avg_q;
    case (state_q)
      S_EXEC: div_req.start = sample_div;
      S_DIVB: begin
        div_req.start    = div_done;
        div_req.dividend = total_q;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= AVG_RST; th_q <= TH_RST; tl_q <= TL_RST; clr_en_q <= 1'b0;
      floor_q <= FLOOR_RST; ceil_q <= CEIL_RST;
      ch_q <= '0; idx_q <= '0; enabled_q <= 1'b0; ready_q <= 1'b0;
      restart_q <= 1'b0; event_q <= 1'b0; bad_q <= 1'b0;
      rc_q <= '0; wp_q <= '0; flags_q <= '0; total_q <= '0; acc_q <= '0;
      rsum_q <= '0; out_valid_q <= 1'b0; bq_q <= '0; tq_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pend_q[i] <= '0;
        bsum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AVG:   avg_q    <= cfg_data_i[CNT_W-1:0];
          CFG_TH:    th_q     <= cfg_data_i[CNT_W-1:0];
          CFG_TL:    tl_q     <= cfg_data_i[CNT_W-1:0];
          CFG_CLEAR: clr_en_q <= cfg_data_i[0];
          CFG_FLOOR: floor_q  <= cfg_data_i[SUM_W-1:0];
          CFG_CEIL:  ceil_q   <= cfg_data_i[SUM_W-1:0];
          default:   avg_q    <= avg_q;
        endcase
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: if (accept) idx_q <= ch_q;
        S_EXEC: begin
          bad_q <= 1'b0;
          if (!sample_div) idx_q <= '0;
          case (func_e'(func_q))
            FUNC_SAMPLE: begin
              if (restart_q) begin
                restart_q <= 1'b0;
                rc_q <= '0; wp_q <= '0; rsum_q <= '0;
                for (int i = 0; i < CHANNELS; i++) pend_q[i] <= '0;
              end else if (!ready_q) begin
                pend_q[idx_q] <= pend_sat;
                rc_q <= rc_new;
                acc_q <= '0;
                if (win_end) wp_q <= wp_q + 1'b1;
              end
            end
            FUNC_ADVANCE: ch_q <= last_ch ? '0 : ch_q + 1'b1;
            FUNC_START: begin
              ch_q <= '0; ready_q <= 1'b0; restart_q <= 1'b0;
              rc_q <= '0; wp_q <= '0; event_q <= 1'b0; flags_q <= '0;
              total_q <= '0; rsum_q <= '0; clr_en_q <= 1'b0;
              enabled_q <= 1'b1;
              for (int i = 0; i < CHANNELS; i++) begin
                pend_q[i] <= '0;
                bsum_q[i] <= '0;
              end
            end
            FUNC_STOP: enabled_q <= 1'b0;
            FUNC_RESTART: begin
              flags_q <= '0; restart_q <= 1'b1;
              ch_q <= LAST_CH; enabled_q <= 1'b1;
            end
            default: enabled_q <= enabled_q;
          endcase
        end
        S_DIVB: if (div_done) bq_q <= div_quot[SUM_W-1:0];
        S_DIVT: if (div_done) tq_q <= div_quot;
        S_EVAL: begin
          rc_q    <= win_end ? '0 : rc_new;
          rsum_q  <= last_ch ? '0 : rs_new;
          flags_q <= flags_new;
          event_q <= ev_new;
          wp_q    <= wp_new;
          acc_q   <= '0;
          if (wp_new == WP_SAMPLE) begin
            pend_q[idx_q] <= pend_sat;
            idx_q <= '0;
          end else if (wp_new >= WP_GROUP) begin
            wp_q <= '0;
            event_q <= 1'b0;
            idx_q <= '0;
            // an event in the group keeps the old baselines
            if (ev_new) begin
              for (int i = 0; i < CHANNELS; i++) pend_q[i] <= '0;
            end
          end else begin
            idx_q <= '0;
          end
        end
        S_LATCH: begin
          bsum_q[idx_q] <= pend_q[idx_q];
          pend_q[idx_q] <= '0;
          acc_q <= acc_sat;
          if (idx_q == LAST_CH) begin
            total_q <= acc_sat;
            ready_q <= 1'b1;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (bsum_q[idx_q] < floor_q || bsum_q[idx_q] > ceil_q) bad_q <= 1'b1;
          if (idx_q != LAST_CH) idx_q <= idx_q + 1'b1;
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tuser;
      adc_q  <= s_axis_tdata[ADC_W-1:0];
    end
  end

  status_e status;
  always_comb begin
    if (!enabled_q)      status = STAT_OFF;
    else if (!ready_q)   status = STAT_NOT_READY;
    else if (bad_q)      status = STAT_RANGE;
    else if (flags_q != '0) status = STAT_FALL;
    else                 status = STAT_NORMAL;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= {enabled_q, LIT_W'(ch_q), status, flags_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `IRCF_ASSERT(a_ready_falls_on_start, clk_i, rst_ni,
    $fell(ready_q) |-> ($past(state_q) == S_EXEC && $past(func_q) == FUNC_START))
  `IRCF_ASSERT(a_phase_bounded, clk_i, rst_ni, wp_q < WP_GROUP)
  `IRCF_ASSERT(a_div_done_in_div, clk_i, rst_ni,
    div_done |-> (state_q == S_DIVB || state_q == S_DIVT))
  `IRCF_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> state_q == S_IDLE)

endmodule

@@ dv/ir_curtain_fall_detector_test.sv @@
// ----------------------------------------------------------------------------
// ir_curtain_fall_detector_test
// self-checking bench: a short table of directed requests, then well-formed
// scan rounds with random levels, spikes and noise under several register
// settings; results checked against typed rows or in-bench scanner model
// ----------------------------------------------------------------------------
module ir_curtain_fall_detector_test;
  import ircf_pkg::*;

  localparam int NCH = 16;
  localparam int SETTLE = 200;
  localparam int LIMIT = 3000000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned SUM_SAT = 20'hFFFFF;
  localparam int unsigned TOT_SAT = 24'hFFFFFF;
  localparam int unsigned RND_SAT = 14'h3FFF;
  localparam int unsigned CNT_SAT = 10'h3FF;

  typedef struct packed {
    logic              led;
    logic [LIT_W-1:0]  lit;
    logic [STATUS_W-1:0] status;
    logic [FLAG_W-1:0] flags;
  } reading_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [ADC_W-1:0]  smp;
    bit                typed;
    reading_t          want;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [FUNC_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ir_curtain_fall_detector dut (.*);

  // scanner model state
  int unsigned avg_rounds, th_hi, th_lo, clr_en, floor_v, ceil_v;
  int unsigned chan, on, rdy, restart_pend, rounds, wphase, evt, flg;
  int unsigned pend[NCH];
  int unsigned base_sum[NCH];
  int unsigned base_tot, rsum;

  reading_t reading_q[$];
  int errors = 0;
  int cycles = 0;
  bit tx_burst = 0, rx_burst = 0;
  int rx_stall = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned sat(int unsigned a, int unsigned b, int unsigned mx);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > mx) ? mx : int'(s);
  endfunction

  function automatic void clear_model();
    chan = 0; on = 0; rdy = 0; restart_pend = 0; rounds = 0; wphase = 0;
    evt = 0; flg = 0; base_tot = 0; rsum = 0;
    foreach (pend[i]) begin
      pend[i] = 0;
      base_sum[i] = 0;
    end
  endfunction

  function automatic void latch_base();
    int unsigned t;
    t = 0;
    foreach (pend[i]) begin
      base_sum[i] = pend[i];
      t = sat(t, pend[i], TOT_SAT);
    end
    base_tot = t;
  endfunction

  function automatic void scan_sample(int unsigned adc);
    int unsigned ch, b, dv;
    bit last;
    ch = chan % NCH;
    last = (ch == NCH - 1);
    dv = (avg_rounds != 0) ? avg_rounds : 1;
    if (restart_pend != 0) begin
      restart_pend = 0;
      foreach (pend[i]) pend[i] = 0;
      rounds = 0; wphase = 0; rsum = 0;
      return;
    end
    if (rdy == 0) begin
      pend[ch] = sat(pend[ch], adc, SUM_SAT);
      if (ch == 0) rounds = sat(rounds, 1, CNT_SAT);
      if (rounds >= avg_rounds && last) begin
        wphase++;
        latch_base();
        foreach (pend[i]) pend[i] = 0;
        rdy = 1;
      end
      return;
    end
    if (ch == 0) rounds = sat(rounds, 1, CNT_SAT);
    rsum = sat(rsum, adc, RND_SAT);
    b = base_sum[ch] / dv;
    if (adc > b + th_hi) begin
      flg |= (1 << ch);
      evt = 1;
    end
    if (last && rsum > base_tot / dv + 3 * th_hi) begin
      flg = 16'hFFFF;
      evt = 1;
    end
    if (clr_en != 0 && adc < b + th_lo && adc + th_lo > b) flg &= ~(1 << ch);
    if (last) rsum = 0;
    if (rounds >= avg_rounds && last) begin
      wphase++;
      rounds = 0;
    end
    if (wphase == WP_SAMPLE) begin
      pend[ch] = sat(pend[ch], adc, SUM_SAT);
    end else if (wphase >= WP_GROUP) begin
      if (evt == 0) latch_base();
      foreach (pend[i]) pend[i] = 0;
      wphase = 0;
      evt = 0;
    end
  endfunction

  function automatic reading_t predict_reading(logic [FUNC_W-1:0] fn, logic [ADC_W-1:0] smp);
    reading_t r;
    bit oor;
    case (fn)
      FUNC_SAMPLE:  scan_sample(smp);
      FUNC_ADVANCE: chan = (chan + 1) % NCH;
      FUNC_START: begin
        clear_model();
        clr_en = 0;
        on = 1;
      end
      FUNC_STOP:    on = 0;
      FUNC_RESTART: begin
        flg = 0; restart_pend = 1; chan = NCH - 1; on = 1;
      end
      default: ;
    endcase
    oor = 0;
    foreach (base_sum[i]) if (base_sum[i] < floor_v || base_sum[i] > ceil_v) oor = 1;
    r.flags = flg[15:0];
    r.lit = chan[3:0];
    r.led = on[0];
    if (on == 0) r.status = STAT_OFF;
    else if (rdy == 0) r.status = STAT_NOT_READY;
    else if (oor) r.status = STAT_RANGE;
    else if (flg != 0) r.status = STAT_FALL;
    else r.status = STAT_NORMAL;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result side: random stalls, compare against the oldest prediction
  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (reading_q.size() == 0) begin
        report_mismatch("unexpected result", int'(got), 0);
      end else begin
        want = reading_q.pop_front();
        if (got.flags !== want.flags) report_mismatch("fall_flags", got.flags, want.flags);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.lit !== want.lit) report_mismatch("lit_channel", got.lit, want.lit);
        if (got.led !== want.led) report_mismatch("led_drive", got.led, want.led);
      end
      rx_stall = rx_burst ? 0 : $urandom_range(0, 16);
      m_axis_tready <= (rx_stall == 0);
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= (rx_stall == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(logic [FUNC_W-1:0] fn, logic [ADC_W-1:0] smp,
                              bit typed = 0, reading_t want = '0);
    int gap;
    reading_t r;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {{(IN_DATA_W-ADC_W){1'b0}}, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_reading(fn, smp);
    reading_q.push_back(typed ? want : r);
    if ($urandom_range(0, 40) == 0) tx_burst = !tx_burst;
    if ($urandom_range(0, 40) == 0) rx_burst = !rx_burst;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_AVG:   avg_rounds = v[9:0];
      CFG_TH:    th_hi = v[9:0];
      CFG_TL:    th_lo = v[9:0];
      CFG_CLEAR: clr_en = v[0];
      CFG_FLOOR: floor_v = v;
      CFG_CEIL:  ceil_v = v;
      default: ;
    endcase
  endtask

  // start, then registers (start zeroes clear enable), then scan rounds
  task automatic run_setting(int unsigned avg, int unsigned hi, int unsigned lo,
                             int unsigned clr, int unsigned fl, int unsigned cl, int n);
    int unsigned level;
    int cnt;
    int unsigned v;
    send_request(FUNC_START, ADC_W'($urandom_range(0, 1023)));
    drain();
    write_reg(CFG_AVG, CFG_DATA_W'(avg));
    write_reg(CFG_TH, CFG_DATA_W'(hi));
    write_reg(CFG_TL, CFG_DATA_W'(lo));
    write_reg(CFG_CLEAR, CFG_DATA_W'(clr));
    write_reg(CFG_FLOOR, CFG_DATA_W'(fl));
    write_reg(CFG_CEIL, CFG_DATA_W'(cl));
    level = $urandom_range(0, 1023);
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 99))
        0: send_request(FUNC_STOP, ADC_W'($urandom_range(0, 1023)));
        1: send_request(FUNC_RESTART, ADC_W'($urandom_range(0, 1023)));
        2: send_request(FUNC_UNUSED - FUNC_W'($urandom_range(0, 2)),
                        ADC_W'($urandom_range(0, 1023)));
        3: send_request(FUNC_ADVANCE, ADC_W'($urandom_range(0, 1023)));
        4: level = $urandom_range(0, 1023);
        default: begin
          if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 1023);
          else v = level + $urandom_range(0, 12);
          if (v > 1023) v = 1023;
          send_request(FUNC_SAMPLE, ADC_W'(v));
          send_request(FUNC_ADVANCE, ADC_W'($urandom_range(0, 1023)));
        end
      endcase
      cnt += 2;
    end
    drain();
  endtask

  row_t dir_rows[$];

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_SAMPLE;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_AVG;
    cfg_data_i = '0;
    avg_rounds = AVG_RST; th_hi = TH_RST; th_lo = TL_RST; clr_en = 0;
    floor_v = FLOOR_RST; ceil_v = CEIL_RST;
    clear_model();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_rows = '{
      '{FUNC_SAMPLE,  10'd5,    1, '{1'b0, 4'd0,  STAT_OFF,       16'h0}},
      '{FUNC_ADVANCE, 10'd0,    1, '{1'b0, 4'd1,  STAT_OFF,       16'h0}},
      '{FUNC_UNUSED,  10'h3FF,  1, '{1'b0, 4'd1,  STAT_OFF,       16'h0}},
      '{FUNC_START,   10'd0,    1, '{1'b1, 4'd0,  STAT_NOT_READY, 16'h0}},
      '{FUNC_STOP,    10'd0,    1, '{1'b0, 4'd0,  STAT_OFF,       16'h0}},
      '{FUNC_RESTART, 10'd0,    1, '{1'b1, 4'd15, STAT_NOT_READY, 16'h0}},
      '{FUNC_SAMPLE,  10'h3FF,  1, '{1'b1, 4'd15, STAT_NOT_READY, 16'h0}},
      '{FUNC_SAMPLE,  10'h3FF,  0, '0},
      '{FUNC_ADVANCE, 10'h2AA,  0, '0},
      '{FUNC_SAMPLE,  10'd0,    0, '0},
      '{FUNC_STOP,    10'h155,  0, '0},
      '{FUNC_SAMPLE,  10'd512,  0, '0},
      '{FUNC_UNUSED - 3'd1, 10'd1, 0, '0},
      '{FUNC_UNUSED - 3'd2, 10'd2, 0, '0},
      '{FUNC_START,   10'h3FF,  1, '{1'b1, 4'd0,  STAT_NOT_READY, 16'h0}}
    };
    foreach (dir_rows[i])
      send_request(dir_rows[i].fn, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    drain();

    run_setting(1, 100, 50, 1, 300, 368280, 360);
    run_setting(2, 0, 0, 1, 0, 20'hFFFFF, 300);
    run_setting(3, 1023, 1023, 1, 0, 0, 240);
    run_setting(0, 20, 30, 1, 20'hFFFFF, 20'hFFFFF, 240);
    run_setting(1, 40, 8, 0, 100, 5000, 300);
    run_setting(1023, 5, 1, 1, 0, 20'hFFFFF, 60);
    run_setting(4, 60, 40, 1, 0, 20'hFFFFF, 200);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
